FILE: rtl/qse_pkg.sv
// Shared constants and types for the quicksort engine.
`default_nettype none
package qse_pkg;

   localparam int DATA_W            = 32;
   localparam int INDEX_W           = 9;
   localparam int CMP_W             = 17;
   localparam int ECNT_W            = 10;
   localparam int DEF_CAPACITY      = 512;
   localparam int DEF_STACK_ENTRIES = 16;

   localparam logic [CMP_W-1:0]  CMP_MAX  = '1;
   localparam logic [ECNT_W-1:0] ECNT_MAX = '1;

   localparam logic       FUNC_LOAD = 1'b0;
   localparam logic       FUNC_READ = 1'b1;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_RANGE    = 2'd2;

   // Sorter status seen by the front end
   typedef struct packed {
      logic busy;
      logic done;
   } sort_status_type;

endpackage
`default_nettype wire

FILE: rtl/qse_ram.sv
// Element store: one write port, one registered read port.
`default_nettype none
module qse_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  wire                        clock,
   input  wire                        we,
   input  wire [AW-1:0]               waddr,
   input  wire [qse_pkg::DATA_W-1:0]  wdata,
   input  wire                        re,
   input  wire [AW-1:0]               raddr,
   output logic [qse_pkg::DATA_W-1:0] rdata_ff
);
   import qse_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   // Write and read the array; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/qse_sorter.sv
// Lomuto partition sequencer with explicit range stack.
`default_nettype none
module qse_sorter #(
   parameter int AW            = 9,
   parameter int CNT_W         = 10,
   parameter int STACK_ENTRIES = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          sort_start,
   input  wire  [CNT_W-1:0]             elem_cnt,
   output qse_pkg::sort_status_type     status,
   output logic [qse_pkg::CMP_W-1:0]    cmp_count,
   output logic                         mem_we,
   output logic [AW-1:0]                mem_waddr,
   output logic [qse_pkg::DATA_W-1:0]   mem_wdata,
   output logic                         mem_re,
   output logic [AW-1:0]                mem_raddr,
   input  wire  [qse_pkg::DATA_W-1:0]   mem_rdata
);
   import qse_pkg::*;

   localparam int SP_W = $clog2(STACK_ENTRIES + 1);
   localparam int SI_W = $clog2(STACK_ENTRIES);
   localparam int SUMW = ((AW > CMP_W) ? AW : CMP_W) + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_PIVOT, S_PIVOT_GET, S_SCAN, S_EVAL, S_SWAP_RD, S_SWAP_WR1,
      S_SWAP_WR2, S_FIN_RD, S_FIN_WR1, S_FIN_WR2, S_NEXT, S_POP, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     lo_ff, lo_in, hi_ff, hi_in, k_ff, k_in, dst_ff, dst_in;
   logic [DATA_W-1:0] pivot_ff, pivot_in, val_ff, val_in;
   logic [CMP_W-1:0]  cmp_ff, cmp_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [2*AW-1:0]   stack_ff [STACK_ENTRIES];
   logic              push;
   logic [SI_W-1:0]   push_idx, pop_idx;
   logic [SP_W-1:0]   sp_dec;
   logic [SUMW-1:0]   cmp_sum;
   logic [AW-1:0]     lsize, rsize, blo, bhi, slo, shi;
   logic              big_ok, small_ok;

   // Split sizes around the pivot position
   always_comb begin
      lsize = dst_ff - lo_ff;
      rsize = hi_ff - dst_ff;
      if (lsize >= rsize) begin
         blo = lo_ff;          bhi = dst_ff - 1'b1; big_ok = lsize >= AW'(2);
         slo = dst_ff + 1'b1;  shi = hi_ff;         small_ok = rsize >= AW'(2);
      end else begin
         blo = dst_ff + 1'b1;  bhi = hi_ff;         big_ok = rsize >= AW'(2);
         slo = lo_ff;          shi = dst_ff - 1'b1; small_ok = lsize >= AW'(2);
      end
   end

   assign sp_dec   = sp_ff - 1'b1;
   assign pop_idx  = sp_dec[SI_W-1:0];
   assign push_idx = sp_ff[SI_W-1:0];
   assign push     = (state_ff == S_NEXT) && big_ok && (sp_ff < SP_W'(STACK_ENTRIES));
   assign cmp_sum  = SUMW'(cmp_ff) + SUMW'(hi_ff - lo_ff);

   // Sequence the partition steps
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      k_in      = k_ff;
      dst_in    = dst_ff;
      pivot_in  = pivot_ff;
      val_in    = val_ff;
      cmp_in    = cmp_ff;
      sp_in     = sp_ff;
      mem_we    = 1'b0;
      mem_waddr = k_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (sort_start) begin
               cmp_in = '0;
               sp_in  = '0;
               lo_in  = '0;
               hi_in  = AW'(elem_cnt - 1'b1);
               state_in = (elem_cnt < CNT_W'(2)) ? S_DONE : S_PIVOT;
            end
         end
         S_PIVOT: begin
            mem_re    = 1'b1;
            mem_raddr = hi_ff;
            cmp_in    = (cmp_sum >= SUMW'(CMP_MAX)) ? CMP_MAX : cmp_sum[CMP_W-1:0];
            dst_in    = lo_ff;
            k_in      = lo_ff;
            state_in  = S_PIVOT_GET;
         end
         S_PIVOT_GET: begin
            pivot_in = mem_rdata;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (k_ff == hi_ff) begin
               state_in = S_FIN_RD;
            end else begin
               mem_re   = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            val_in = mem_rdata;
            if ($signed(mem_rdata) < $signed(pivot_ff)) begin
               state_in = S_SWAP_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SWAP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = dst_ff;
            state_in  = S_SWAP_WR1;
         end
         S_SWAP_WR1: begin
            mem_we   = 1'b1;
            state_in = S_SWAP_WR2;
         end
         S_SWAP_WR2: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = val_ff;
            dst_in    = dst_ff + 1'b1;
            k_in      = k_ff + 1'b1;
            state_in  = S_SCAN;
         end
         S_FIN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = dst_ff;
            state_in  = S_FIN_WR1;
         end
         S_FIN_WR1: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            state_in  = S_FIN_WR2;
         end
         S_FIN_WR2: begin
            mem_we    = 1'b1;
            mem_waddr = dst_ff;
            mem_wdata = pivot_ff;
            state_in  = S_NEXT;
         end
         S_NEXT: begin
            if (push) begin
               sp_in = sp_ff + 1'b1;
            end
            if (small_ok) begin
               lo_in    = slo;
               hi_in    = shi;
               state_in = S_PIVOT;
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               state_in = S_DONE;
            end else begin
               sp_in    = sp_dec;
               lo_in    = stack_ff[pop_idx][2*AW-1:AW];
               hi_in    = stack_ff[pop_idx][AW-1:0];
               state_in = S_PIVOT;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state, pointers and counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cmp_ff   <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cmp_ff   <= cmp_in;
         sp_ff    <= sp_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      k_ff     <= k_in;
      dst_ff   <= dst_in;
      pivot_ff <= pivot_in;
      val_ff   <= val_in;
      if (push) begin
         stack_ff[push_idx] <= {blo, bhi};
      end
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = (state_ff == S_DONE);
   assign cmp_count   = cmp_ff;

endmodule
`default_nettype wire

FILE: rtl/quicksort_engine.sv
// Quicksort engine top level: load/read front end, element store and sorter.
//
// Request channel (req_*): func 0 loads req_value into the next store slot;
// req_last on a load ends the list and sorts it in place. func 1 reads the
// element at req_index. Result channel (rsp_*) carries one transaction per
// read, per last load, and per dropped load (error 1).
// Loads and reads are taken one per cycle while req_ready is high. A read result
// passes through the store read stage and then the output register. A last load
// first waits for queued results to drain, then the sorter runs: for each
// range it fetches the pivot, reads each element scanned, swaps one that is
// below the pivot with a read and two writes, places the pivot with a read
// and two writes, then picks the next range (one more step when one is popped).
// The result with the element and comparison counts follows the sort.
// While the sort runs, req_ready stays low.
// Reset empties the list, clears the comparison count and drops any queued
// result; store contents are kept but unreachable. When rsp_ready is low the
// output register holds its transaction and the front end accepts further
// requests only while the internal read stage has room.
`default_nettype none
module quicksort_engine #(
   parameter int CAPACITY      = qse_pkg::DEF_CAPACITY,
   parameter int STACK_ENTRIES = qse_pkg::DEF_STACK_ENTRIES
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire                           req_func,
   input  wire  signed [qse_pkg::DATA_W-1:0] req_value,
   input  wire                           req_last,
   input  wire  [qse_pkg::INDEX_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic signed [qse_pkg::DATA_W-1:0] rsp_read_value,
   output logic [qse_pkg::CMP_W-1:0]     rsp_comparison_count,
   output logic [qse_pkg::ECNT_W-1:0]    rsp_element_count,
   output logic [1:0]                    rsp_error
);
   import qse_pkg::*;

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int EW    = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;

   typedef enum logic [1:0] {T_RUN, T_DRAIN, T_SORT} state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, base;
   logic              pending_ff, pending_in;
   logic              s1_valid_ff, s1_valid_in, s1_rd_ok_ff, s1_rd_ok_in;
   logic [1:0]        s1_err_ff, s1_err_in;
   logic [CMP_W-1:0]  s1_cmp_ff, s1_cmp_in;
   logic [ECNT_W-1:0] s1_ecnt_ff, s1_ecnt_in;
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_value_ff;
   logic [CMP_W-1:0]  out_cmp_ff;
   logic [ECNT_W-1:0] out_ecnt_ff;
   logic [1:0]        out_err_ff;
   logic [1:0]        last_err_ff, last_err_in;
   logic              accept, s1_adv, sort_start, fits, rd_ok;
   logic [CW-1:0]     idx_x;
   logic [EW-1:0]     cnt_x;
   logic [ECNT_W-1:0] ecnt_sat;
   sort_status_type   sort_status;
   logic [CMP_W-1:0]  cmp_count;
   logic              fe_we, fe_re, so_we, so_re, m_we, m_re;
   logic [AW-1:0]     fe_waddr, fe_raddr, so_waddr, so_raddr, m_waddr, m_raddr;
   logic [DATA_W-1:0] so_wdata, m_wdata, rdata;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = (state_ff == T_RUN) && (!s1_valid_ff || s1_adv);
   assign accept     = req_valid && req_ready;
   assign sort_start = (state_ff == T_DRAIN) && !s1_valid_ff;

   // Decode the load slot and the read range
   assign base  = pending_ff ? '0 : cnt_ff;
   assign fits  = base < CNT_W'(CAPACITY);
   assign idx_x = CW'(req_index);
   assign rd_ok = idx_x < CW'(cnt_ff);

   assign fe_we    = accept && (req_func == FUNC_LOAD) && fits;
   assign fe_waddr = base[AW-1:0];
   assign fe_re    = accept && (req_func == FUNC_READ);
   assign fe_raddr = idx_x[AW-1:0];

   // Saturate the element count for the result
   assign cnt_x    = EW'(cnt_in);
   assign ecnt_sat = (cnt_x > EW'(ECNT_MAX)) ? ECNT_MAX : cnt_x[ECNT_W-1:0];

   // Front end control and read stage
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pending_in  = pending_ff;
      last_err_in = last_err_ff;
      s1_valid_in = s1_adv ? 1'b0 : s1_valid_ff;
      s1_rd_ok_in = s1_rd_ok_ff;
      s1_err_in   = s1_err_ff;
      s1_cmp_in   = s1_cmp_ff;
      s1_ecnt_in  = s1_ecnt_ff;
      if (accept && (req_func == FUNC_LOAD)) begin
         cnt_in     = fits ? base + 1'b1 : base;
         pending_in = req_last;
      end
      unique case (state_ff)
         T_RUN: begin
            if (accept) begin
               if (req_func == FUNC_READ) begin
                  s1_valid_in = 1'b1;
                  s1_rd_ok_in = rd_ok;
                  s1_err_in   = rd_ok ? ERR_NONE : ERR_RANGE;
                  s1_cmp_in   = cmp_count;
                  s1_ecnt_in  = ecnt_sat;
               end else if (req_last) begin
                  last_err_in = fits ? ERR_NONE : ERR_OVERFLOW;
                  state_in    = T_DRAIN;
               end else if (!fits) begin
                  s1_valid_in = 1'b1;
                  s1_rd_ok_in = 1'b0;
                  s1_err_in   = ERR_OVERFLOW;
                  s1_cmp_in   = cmp_count;
                  s1_ecnt_in  = ecnt_sat;
               end
            end
         end
         T_DRAIN: begin
            if (sort_start) begin
               state_in = T_SORT;
            end
         end
         T_SORT: begin
            if (sort_status.done) begin
               s1_valid_in = 1'b1;
               s1_rd_ok_in = 1'b0;
               s1_err_in   = last_err_ff;
               s1_cmp_in   = cmp_count;
               s1_ecnt_in  = ecnt_sat;
               state_in    = T_RUN;
            end
         end
         default: begin
            state_in = T_RUN;
         end
      endcase
   end

   // Hold front end state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_RUN;
         cnt_ff       <= '0;
         pending_ff   <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         pending_ff  <= pending_in;
         s1_valid_ff <= s1_valid_in;
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      last_err_ff <= last_err_in;
      s1_rd_ok_ff <= s1_rd_ok_in;
      s1_err_ff   <= s1_err_in;
      s1_cmp_ff   <= s1_cmp_in;
      s1_ecnt_ff  <= s1_ecnt_in;
      if (s1_adv) begin
         out_value_ff <= s1_rd_ok_ff ? rdata : '0;
         out_cmp_ff   <= s1_cmp_ff;
         out_ecnt_ff  <= s1_ecnt_ff;
         out_err_ff   <= s1_err_ff;
      end
   end

   // Hand the store port to the sorter while it runs
   always_comb begin
      if (state_ff == T_SORT) begin
         m_we = so_we; m_waddr = so_waddr; m_wdata = so_wdata;
         m_re = so_re; m_raddr = so_raddr;
      end else begin
         m_we = fe_we; m_waddr = fe_waddr; m_wdata = req_value;
         m_re = fe_re; m_raddr = fe_raddr;
      end
   end

   qse_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock    (clock),
      .we       (m_we),
      .waddr    (m_waddr),
      .wdata    (m_wdata),
      .re       (m_re),
      .raddr    (m_raddr),
      .rdata_ff (rdata)
   );

   qse_sorter #(
      .AW            (AW),
      .CNT_W         (CNT_W),
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .sort_start (sort_start),
      .elem_cnt   (cnt_ff),
      .status     (sort_status),
      .cmp_count  (cmp_count),
      .mem_we     (so_we),
      .mem_waddr  (so_waddr),
      .mem_wdata  (so_wdata),
      .mem_re     (so_re),
      .mem_raddr  (so_raddr),
      .mem_rdata  (rdata)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_read_value       = out_value_ff;
   assign rsp_comparison_count = out_cmp_ff;
   assign rsp_element_count    = out_ecnt_ff;
   assign rsp_error            = out_err_ff;

   // No request is taken while the sorter owns the store
   a_no_accept_in_sort: assert property (@(posedge clock) disable iff (reset)
      sort_status.busy |-> !req_ready)
      else $error("request accepted during sort");

   // Sort starts only with the read stage empty
   a_start_drained: assert property (@(posedge clock) disable iff (reset)
      sort_start |-> !s1_valid_ff && !out_valid_ff || !s1_valid_ff)
      else $error("sort started with pending read");

   // A range error never carries data
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_err_ff == ERR_RANGE) |-> out_value_ff == '0)
      else $error("range error with data");

   // Element count never exceeds capacity
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the quicksort engine: load, sort and read transactions.
`timescale 1ns / 1ps
module tb_top;
   import qse_pkg::*;

   localparam int CAP        = DEF_CAPACITY;
   localparam int STK        = DEF_STACK_ENTRIES;
   localparam int CYCLE_MAX  = 5000000;
   localparam int BIG_STALL  = 400;

   typedef struct {
      logic              func;
      logic [DATA_W-1:0] value;
      logic              last;
      logic [INDEX_W-1:0] index;
      bit                drain;
   } sort_req_t;

   typedef struct {
      logic [DATA_W-1:0] read_value;
      logic [CMP_W-1:0]  cmp_count;
      logic [ECNT_W-1:0] elem_count;
      logic [1:0]        error;
   } sort_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_func = FUNC_LOAD;
   logic signed [DATA_W-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic [INDEX_W-1:0] req_index = '0;
   logic rsp_ready = 1'b0;
   wire  req_ready;
   wire  rsp_valid;
   wire  signed [DATA_W-1:0] rsp_read_value;
   wire  [CMP_W-1:0]  rsp_comparison_count;
   wire  [ECNT_W-1:0] rsp_element_count;
   wire  [1:0]        rsp_error;

   quicksort_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_value(req_value), .req_last(req_last), .req_index(req_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_comparison_count(rsp_comparison_count),
      .rsp_element_count(rsp_element_count), .rsp_error(rsp_error)
   );

   always #5 clock = ~clock;

   sort_req_t pending_reqs[$];
   sort_rsp_t expected_rsps[$];
   int        failures = 0;
   int        cycles = 0;
   int        results_seen = 0;

   // Shadow copy of the engine state
   logic [DATA_W-1:0] shadow_store[CAP];
   int  shadow_count = 0;
   int  shadow_cmp = 0;
   bit  shadow_new_list = 1'b1;

   function automatic bit signed_less(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic void swap_slots(int x, int y);
      logic [DATA_W-1:0] t;
      t = shadow_store[x];
      shadow_store[x] = shadow_store[y];
      shadow_store[y] = t;
   endfunction

   // Lomuto partition of [lo, hi], last element as pivot
   function automatic int partition_range(int lo, int hi);
      logic [DATA_W-1:0] pivot;
      int dst;
      pivot = shadow_store[hi];
      dst = lo;
      shadow_cmp = shadow_cmp + (hi - lo);
      if (shadow_cmp > int'(CMP_MAX)) shadow_cmp = int'(CMP_MAX);
      for (int k = lo; k < hi; k++) begin
         if (signed_less(shadow_store[k], pivot)) begin
            swap_slots(dst, k);
            dst++;
         end
      end
      swap_slots(dst, hi);
      return dst;
   endfunction

   // Sort the shadow store, pushing the larger side, looping on the smaller
   function automatic void sort_shadow();
      int stk_lo[STK];
      int stk_hi[STK];
      int sp, lo, hi, p, lsize, rsize, blo, bhi, slo, shi;
      bit big_ok, small_ok, run;
      shadow_cmp = 0;
      if (shadow_count < 2) return;
      stk_lo[0] = 0;
      stk_hi[0] = shadow_count - 1;
      sp = 1;
      while (sp > 0) begin
         sp--;
         lo = stk_lo[sp];
         hi = stk_hi[sp];
         run = 1'b1;
         while (run && lo < hi) begin
            p = partition_range(lo, hi);
            lsize = p - lo;
            rsize = hi - p;
            if (lsize >= rsize) begin
               blo = lo; bhi = p - 1; big_ok = lsize >= 2;
               slo = p + 1; shi = hi; small_ok = rsize >= 2;
            end else begin
               blo = p + 1; bhi = hi; big_ok = rsize >= 2;
               slo = lo; shi = p - 1; small_ok = lsize >= 2;
            end
            if (big_ok && sp < STK) begin
               stk_lo[sp] = blo;
               stk_hi[sp] = bhi;
               sp++;
            end
            if (!small_ok) run = 1'b0;
            else begin
               lo = slo;
               hi = shi;
            end
         end
      end
   endfunction

   // Advance the shadow state by one transaction; returns 1 if it yields a result
   function automatic bit predict_sort_rsp(sort_req_t r, output sort_rsp_t o);
      logic [1:0] err;
      logic [DATA_W-1:0] rv;
      err = ERR_NONE;
      rv = '0;
      if (r.func == FUNC_LOAD) begin
         if (shadow_new_list) begin
            shadow_count = 0;
            shadow_new_list = 1'b0;
         end
         if (shadow_count < CAP) begin
            shadow_store[shadow_count] = r.value;
            shadow_count++;
         end else err = ERR_OVERFLOW;
         if (r.last) begin
            sort_shadow();
            shadow_new_list = 1'b1;
         end else if (err == ERR_NONE) return 1'b0;
      end else begin
         if (int'(r.index) < shadow_count) rv = shadow_store[r.index];
         else err = ERR_RANGE;
      end
      o.read_value = rv;
      o.cmp_count = shadow_cmp[CMP_W-1:0];
      o.elem_count = (shadow_count > int'(ECNT_MAX)) ? ECNT_MAX : shadow_count[ECNT_W-1:0];
      o.error = err;
      return 1'b1;
   endfunction

   // Driver: present pending transactions with random gaps
   int sender_gap = 0;
   int sent_count = 0;
   always @(posedge clock) begin
      sort_req_t nr;
      sort_rsp_t er;
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
         sender_gap <= 0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            nr.func = req_func; nr.value = req_value; nr.last = req_last;
            nr.index = req_index; nr.drain = 1'b0;
            if (predict_sort_rsp(nr, er)) expected_rsps.push_back(er);
         end
         if (req_valid && !taken) begin
            // hold the current transaction
         end else if (sender_gap > 0) begin
            sender_gap <= sender_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      !(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
            nr = pending_reqs.pop_front();
            req_func <= nr.func;
            req_value <= nr.value;
            req_last <= nr.last;
            req_index <= nr.index;
            req_valid <= 1'b1;
            sent_count++;
            // stretches with no idling every other 64 transactions
            sender_gap <= ((sent_count / 64) % 2 == 1) ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check results and stall the result channel
   int receiver_stall = 0;
   always @(posedge clock) begin
      sort_rsp_t ex;
      int s;
      if (reset) begin
         rsp_ready <= 1'b0;
         receiver_stall <= 0;
      end else begin
         s = receiver_stall;
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result value=%0d cmp=%0d cnt=%0d err=%0d", $realtime,
                        rsp_read_value, rsp_comparison_count, rsp_element_count, rsp_error);
               failures++;
            end else begin
               ex = expected_rsps.pop_front();
               if (rsp_read_value !== ex.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d", $realtime,
                           $signed(ex.read_value), rsp_read_value);
                  failures++;
               end
               if (rsp_comparison_count !== ex.cmp_count) begin
                  $display("%0t: comparison_count expected %0d actual %0d", $realtime,
                           ex.cmp_count, rsp_comparison_count);
                  failures++;
               end
               if (rsp_element_count !== ex.elem_count) begin
                  $display("%0t: element_count expected %0d actual %0d", $realtime,
                           ex.elem_count, rsp_element_count);
                  failures++;
               end
               if (rsp_error !== ex.error) begin
                  $display("%0t: error expected %0d actual %0d", $realtime,
                           ex.error, rsp_error);
                  failures++;
               end
            end
            // long hold-off once, so the engine backs up into its input
            if (results_seen == 60) s = BIG_STALL;
            else if ((results_seen / 50) % 2 == 1) s = 0;
            else s = $urandom_range(0, 6);
         end else if (s > 0) s--;
         receiver_stall <= s;
         rsp_ready <= (s == 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_MAX) begin
         $display("quicksort_engine: mismatch");
         $finish;
      end
   end

   // Stimulus generation
   int gen_items = 0;

   task automatic add_load(logic [DATA_W-1:0] v, logic lst, bit drn = 1'b0);
      sort_req_t r;
      r.func = FUNC_LOAD; r.value = v; r.last = lst; r.index = '0; r.drain = drn;
      pending_reqs.push_back(r);
      gen_items++;
   endtask

   task automatic add_read(logic [INDEX_W-1:0] idx, bit drn = 1'b0);
      sort_req_t r;
      r.func = FUNC_READ; r.value = $urandom; r.last = 1'($urandom_range(0, 1));
      r.index = idx; r.drain = drn;
      pending_reqs.push_back(r);
      gen_items++;
   endtask

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 7) - 4;
         1: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int n, cnt;
      // reads before any load are out of range
      add_read(0);
      add_read(9'd511);
      // single element list, then a read past its end
      add_load(32'd5, 1'b1);
      add_read(0);
      add_read(1);
      // extremes of the value range, read before the sort
      add_load(32'h80000000, 1'b0);
      add_load(32'h7fffffff, 1'b0);
      add_read(1);
      add_load(32'h00000000, 1'b0);
      add_load(32'hffffffff, 1'b0);
      add_load(32'h00000001, 1'b1);
      for (int i = 0; i < 5; i++) add_read(INDEX_W'(i));
      // already sorted, reversed and all-equal lists
      for (int i = 0; i < 64; i++) add_load(i, i == 63, i == 0);
      add_read(63);
      for (int i = 0; i < 64; i++) add_load(-i, i == 63);
      add_read(0);
      for (int i = 0; i < 32; i++) add_load(32'd7, i == 31);
      add_read(9'd16);
      // fill the store past capacity; the overflowing loads are flagged
      for (int i = 0; i < CAP + 2; i++) add_load(rand_value(), i == CAP + 1);
      add_read(0, 1'b1);
      add_read(9'd511);
      add_read(9'd300);

      // random lists with reads and occasional noise
      cnt = 0;
      while (gen_items < 700) begin
         n = $urandom_range(1, 24);
         for (int i = 0; i < n; i++) begin
            add_load(rand_value(), i == n - 1, (i == 0) && ($urandom_range(0, 9) == 0));
            if ($urandom_range(0, 7) == 0) add_read(INDEX_W'($urandom_range(0, i + 1)));
         end
         cnt = n;
         for (int i = $urandom_range(1, 6); i > 0; i--) begin
            if ($urandom_range(0, 4) == 0) add_read(INDEX_W'($urandom));
            else add_read(INDEX_W'($urandom_range(0, cnt)));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_valid || expected_rsps.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0)
         $display("quicksort_engine: match");
      else
         $display("quicksort_engine: mismatch");
      $finish;
   end

endmodule
